// ===== design/mlpf_pkg.sv =====
`default_nettype none

package mlpf_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int COUNT_BITS     = 11;
   localparam int TALLY_BITS     = 21;
   localparam int MAX_ROWS       = 1024;
   localparam int MAX_COLUMNS    = 1024;
   localparam int ADDR_BITS      = $clog2(MAX_COLUMNS);
   localparam int CSR_INDEX_BITS = 4;
   localparam int FIFO_DEPTH     = 4;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);

   typedef logic signed [VALUE_BITS-1:0] value_type;
   typedef logic [COUNT_BITS-1:0]        count_type;
   typedef logic [TALLY_BITS-1:0]        tally_type;
   typedef logic [CSR_INDEX_BITS-1:0]    csr_index_type;

   // register indexes of the configuration port
   localparam csr_index_type CSR_ROW_COUNT    = csr_index_type'(0);
   localparam csr_index_type CSR_COLUMN_COUNT = csr_index_type'(1);

   // results caused by one element, waiting to be sent one by one
   typedef struct packed {
      count_type row;
      count_type column;
      logic      peak_up;      // cell above the element
      logic      peak_left;    // bottom-row cell left of the element
      logic      peak_corner;  // bottom-right cell itself
      logic      closing;      // end-of-matrix record
      tally_type base;         // tally before this element
   } bundle_type;

   // zero acts as one, anything above the limit acts as the limit
   function automatic count_type clamp_count(input count_type value, input count_type limit);
      count_type result;
      if (value == '0) begin
         result = count_type'(1);
      end else if (value > limit) begin
         result = limit;
      end else begin
         result = value;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== design/mlpf_req_if.sv =====
`default_nettype none

interface mlpf_req_if;
   logic                valid;
   logic                ready;
   mlpf_pkg::value_type sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink (input valid, input sample_value, output ready);
endinterface

`default_nettype wire

// ===== design/mlpf_rsp_if.sv =====
`default_nettype none

interface mlpf_rsp_if;
   logic                valid;
   logic                ready;
   mlpf_pkg::count_type peak_row;
   mlpf_pkg::count_type peak_column;
   logic                is_peak;
   logic                end_of_matrix;
   mlpf_pkg::tally_type total_peaks;

   modport source (output valid, output peak_row, output peak_column, output is_peak,
                   output end_of_matrix, output total_peaks, input ready);
   modport sink (input valid, input peak_row, input peak_column, input is_peak,
                 input end_of_matrix, input total_peaks, output ready);
endinterface

`default_nettype wire

// ===== design/mlpf_csr_if.sv =====
`default_nettype none

interface mlpf_csr_if;
   logic                    valid;
   logic                    ready;
   mlpf_pkg::csr_index_type index;
   mlpf_pkg::count_type     data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/matrix_local_peak_finder.sv =====
`default_nettype none

// Streaming 2-D local peak finder. Elements of a signed matrix enter in raster order, one
// item per element, at a sustained rate of one item per clock. A cell is a peak when it is
// greater than or equal to each in-bounds up, down, left and right neighbour (plateaus
// count). Each peak is reported as soon as its last neighbour has arrived, with 1-based
// coordinates and the running peak count; the last element of the matrix adds a closing
// item (is_peak low, end_of_matrix high) with the final count and starts the next matrix.
// Results leave one per clock while rsp ready is high, after stage 1 and the queue; an
// element causes at most one result except in the bottom row, where it causes up to two,
// and the last element up to four. Each element's results wait as one bundle in a
// four-entry queue, and req ready drops once the queued bundles plus the element in the
// decision stage reach four, which throttles the input when rsp ready is low or where the
// bottom row makes more results than items. Two 1024 x 32 line memories (row above,
// current row) each take one read and one write per element; the current-row memory is
// read one column ahead so that the right neighbour is at hand. Writing either count
// register drops the matrix in progress; write only while the block is idle.
module matrix_local_peak_finder (
   input  wire logic   clock,
   input  wire logic   reset,
   mlpf_req_if.sink    req_chan,
   mlpf_rsp_if.source  rsp_chan,
   mlpf_csr_if.sink    csr_chan
);

   localparam int OCC_BITS = mlpf_pkg::FIFO_PTR_BITS + 1;

   // ---------------------------------------------------------------- configuration
   mlpf_pkg::count_type row_cnt_ff, row_cnt_in;
   mlpf_pkg::count_type col_cnt_ff, col_cnt_in;
   logic                csr_write;
   logic                csr_restart;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_comb begin
      row_cnt_in  = row_cnt_ff;
      col_cnt_in  = col_cnt_ff;
      csr_restart = 1'b0;
      if (csr_write) begin
         if (csr_chan.index == mlpf_pkg::CSR_ROW_COUNT) begin
            row_cnt_in  = mlpf_pkg::clamp_count(csr_chan.data,
                                                mlpf_pkg::count_type'(mlpf_pkg::MAX_ROWS));
            csr_restart = 1'b1;
         end else if (csr_chan.index == mlpf_pkg::CSR_COLUMN_COUNT) begin
            col_cnt_in  = mlpf_pkg::clamp_count(csr_chan.data,
                                                mlpf_pkg::count_type'(mlpf_pkg::MAX_COLUMNS));
            csr_restart = 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- raster position
   mlpf_pkg::count_type row_ff, row_in;
   mlpf_pkg::count_type col_ff, col_in;
   logic                accept;
   logic                last_col;
   logic                last_row;
   logic                s1_valid_ff;
   logic [OCC_BITS-1:0] cnt_ff, cnt_in;
   logic [OCC_BITS-1:0] occupancy;

   // hold req ready low unless the queue can take whatever is in flight
   assign occupancy      = cnt_ff + {{(OCC_BITS-1){1'b0}}, s1_valid_ff};
   assign req_chan.ready = occupancy < OCC_BITS'(mlpf_pkg::FIFO_DEPTH);
   assign accept         = req_chan.valid && req_chan.ready;
   assign last_col       = col_ff == col_cnt_ff;
   assign last_row       = row_ff == row_cnt_ff;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_restart) begin
         row_in = mlpf_pkg::count_type'(1);
         col_in = mlpf_pkg::count_type'(1);
      end else if (accept) begin
         if (last_col) begin
            col_in = mlpf_pkg::count_type'(1);
            row_in = last_row ? mlpf_pkg::count_type'(1) : row_ff + mlpf_pkg::count_type'(1);
         end else begin
            col_in = col_ff + mlpf_pkg::count_type'(1);
         end
      end
   end

   // ---------------------------------------------------------------- line memories
   // cur_addr is the element's own column; ahead_addr is the column of the next element,
   // whose current-row entry is the right neighbour now and the displaced value next time.
   logic [mlpf_pkg::ADDR_BITS-1:0] cur_addr;
   logic [mlpf_pkg::ADDR_BITS-1:0] ahead_addr;
   mlpf_pkg::value_type            upper_mem [mlpf_pkg::MAX_COLUMNS];
   mlpf_pkg::value_type            centre_mem [mlpf_pkg::MAX_COLUMNS];
   mlpf_pkg::value_type            upper_rd_ff;
   mlpf_pkg::value_type            centre_rd_ff;
   mlpf_pkg::value_type            sample;
   mlpf_pkg::value_type            ahead_src;
   mlpf_pkg::value_type            ahead_eff;
   mlpf_pkg::value_type            ahead_ff;

   assign sample     = req_chan.sample_value;
   assign cur_addr   = mlpf_pkg::ADDR_BITS'(col_ff - mlpf_pkg::count_type'(1));
   assign ahead_addr = last_col ? '0 : col_ff[mlpf_pkg::ADDR_BITS-1:0];

   // push the displaced current-row value into the row above, store the new element
   always_ff @(posedge clock) begin
      if (accept) begin
         centre_mem[cur_addr] <= sample;
         upper_mem[cur_addr]  <= ahead_eff;
         centre_rd_ff         <= centre_mem[ahead_addr];
         upper_rd_ff          <= upper_mem[cur_addr];
      end
   end

   // ---------------------------------------------------------------- stage 1 registers
   mlpf_pkg::value_type x_s1_ff;
   mlpf_pkg::value_type old_s1_ff;
   mlpf_pkg::value_type left_s1_ff;
   mlpf_pkg::value_type px_s1_ff;
   mlpf_pkg::value_type ppx_s1_ff;
   mlpf_pkg::count_type row_s1_ff;
   mlpf_pkg::count_type col_s1_ff;
   logic                fwd_s1_ff;
   mlpf_pkg::value_type pend_ff;
   mlpf_pkg::value_type px_ff;
   mlpf_pkg::value_type ppx_ff;

   // with a single column the look-ahead hits the entry written by the same element
   assign ahead_src = fwd_s1_ff ? x_s1_ff : centre_rd_ff;
   assign ahead_eff = s1_valid_ff ? ahead_src : ahead_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         ahead_ff <= ahead_src;
      end
      if (accept) begin
         x_s1_ff    <= sample;
         old_s1_ff  <= ahead_eff;
         left_s1_ff <= pend_ff;
         px_s1_ff   <= px_ff;
         ppx_s1_ff  <= ppx_ff;
         row_s1_ff  <= row_ff;
         col_s1_ff  <= col_ff;
         fwd_s1_ff  <= col_cnt_ff == mlpf_pkg::count_type'(1);
         pend_ff    <= ahead_eff;
         px_ff      <= sample;
         ppx_ff     <= px_ff;
      end
   end

   // ---------------------------------------------------------------- peak decisions
   logic                s1_last_col;
   logic                s1_bottom;
   logic                peak_up;
   logic                peak_left;
   logic                peak_corner;
   logic                closing;
   logic                push;
   mlpf_pkg::tally_type tally_ff, tally_in;
   mlpf_pkg::bundle_type push_bundle;

   assign s1_last_col = col_s1_ff == col_cnt_ff;
   assign s1_bottom   = row_s1_ff == row_cnt_ff;

   // cell above: its lower neighbour just arrived
   assign peak_up = (row_s1_ff >= mlpf_pkg::count_type'(2)) && (old_s1_ff >= x_s1_ff)
                 && ((row_s1_ff < mlpf_pkg::count_type'(3)) || (old_s1_ff >= upper_rd_ff))
                 && (s1_last_col || (old_s1_ff >= ahead_src))
                 && ((col_s1_ff == mlpf_pkg::count_type'(1)) || (old_s1_ff >= left_s1_ff));

   // bottom-row cell to the left: its right neighbour just arrived
   assign peak_left = s1_bottom && (col_s1_ff >= mlpf_pkg::count_type'(2))
                   && (px_s1_ff >= x_s1_ff)
                   && ((row_cnt_ff < mlpf_pkg::count_type'(2)) || (px_s1_ff >= left_s1_ff))
                   && ((col_s1_ff < mlpf_pkg::count_type'(3)) || (px_s1_ff >= ppx_s1_ff));

   // bottom-right cell: all its neighbours are in
   assign peak_corner = s1_bottom && s1_last_col
                     && ((row_cnt_ff < mlpf_pkg::count_type'(2)) || (x_s1_ff >= old_s1_ff))
                     && ((col_cnt_ff < mlpf_pkg::count_type'(2)) || (x_s1_ff >= px_s1_ff));

   assign closing = s1_bottom && s1_last_col;
   assign push    = s1_valid_ff && (peak_up || peak_left || peak_corner || closing);

   always_comb begin
      push_bundle.row         = row_s1_ff;
      push_bundle.column      = col_s1_ff;
      push_bundle.peak_up     = peak_up;
      push_bundle.peak_left   = peak_left;
      push_bundle.peak_corner = peak_corner;
      push_bundle.closing     = closing;
      push_bundle.base        = tally_ff;
   end

   always_comb begin
      tally_in = tally_ff;
      if (csr_restart) begin
         tally_in = '0;
      end else if (s1_valid_ff) begin
         if (closing) begin
            tally_in = '0;
         end else begin
            tally_in = tally_ff + mlpf_pkg::tally_type'(peak_up)
                     + mlpf_pkg::tally_type'(peak_left);
         end
      end
   end

   // ---------------------------------------------------------------- result queue
   mlpf_pkg::bundle_type             fifo_mem [mlpf_pkg::FIFO_DEPTH];
   logic [mlpf_pkg::FIFO_PTR_BITS-1:0] wr_ptr_ff;
   logic [mlpf_pkg::FIFO_PTR_BITS-1:0] rd_ptr_ff;
   mlpf_pkg::bundle_type             head;
   logic [3:0]                       done_ff, done_in;
   logic [3:0]                       remain;
   logic [3:0]                       sel;
   logic                             out_free;
   logic                             step;
   logic                             pop;
   logic                             rsp_valid_ff;
   mlpf_pkg::count_type              row_out, rsp_row_ff;
   mlpf_pkg::count_type              col_out, rsp_col_ff;
   logic                             peak_out, rsp_peak_ff;
   logic                             end_out, rsp_end_ff;
   mlpf_pkg::tally_type              total_out, rsp_total_ff;

   assign head     = fifo_mem[rd_ptr_ff];
   assign remain   = {head.closing, head.peak_corner, head.peak_left, head.peak_up} & ~done_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign step     = out_free && (cnt_ff != '0);
   assign pop      = step && ((remain & ~sel) == 4'b0000);

   // send the head bundle's results in raster order, oldest cell first
   always_comb begin
      sel       = 4'b1000;
      row_out   = '0;
      col_out   = '0;
      peak_out  = 1'b0;
      end_out   = 1'b1;
      total_out = head.base + mlpf_pkg::tally_type'(head.peak_up)
                + mlpf_pkg::tally_type'(head.peak_left)
                + mlpf_pkg::tally_type'(head.peak_corner);
      if (remain[0]) begin
         sel       = 4'b0001;
         row_out   = head.row - mlpf_pkg::count_type'(1);
         col_out   = head.column;
         peak_out  = 1'b1;
         end_out   = 1'b0;
         total_out = head.base + mlpf_pkg::tally_type'(1);
      end else if (remain[1]) begin
         sel       = 4'b0010;
         row_out   = head.row;
         col_out   = head.column - mlpf_pkg::count_type'(1);
         peak_out  = 1'b1;
         end_out   = 1'b0;
         total_out = head.base + mlpf_pkg::tally_type'(1)
                   + mlpf_pkg::tally_type'(head.peak_up);
      end else if (remain[2]) begin
         sel       = 4'b0100;
         row_out   = head.row;
         col_out   = head.column;
         peak_out  = 1'b1;
         end_out   = 1'b0;
         total_out = head.base + mlpf_pkg::tally_type'(1)
                   + mlpf_pkg::tally_type'(head.peak_up)
                   + mlpf_pkg::tally_type'(head.peak_left);
      end
   end

   always_comb begin
      done_in = done_ff;
      if (step) begin
         done_in = pop ? 4'b0000 : (done_ff | sel);
      end
      cnt_in = cnt_ff + {{(OCC_BITS-1){1'b0}}, push} - {{(OCC_BITS-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= push_bundle;
      end
      if (step) begin
         rsp_row_ff   <= row_out;
         rsp_col_ff   <= col_out;
         rsp_peak_ff  <= peak_out;
         rsp_end_ff   <= end_out;
         rsp_total_ff <= total_out;
      end
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff   <= mlpf_pkg::count_type'(1);
         col_cnt_ff   <= mlpf_pkg::count_type'(1);
         row_ff       <= mlpf_pkg::count_type'(1);
         col_ff       <= mlpf_pkg::count_type'(1);
         tally_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         cnt_ff       <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         tally_ff   <= tally_in;
         cnt_ff     <= cnt_in;
         done_ff    <= done_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + {{(mlpf_pkg::FIFO_PTR_BITS-1){1'b0}}, 1'b1};
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + {{(mlpf_pkg::FIFO_PTR_BITS-1){1'b0}}, 1'b1};
         end
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.peak_row      = rsp_row_ff;
   assign rsp_chan.peak_column   = rsp_col_ff;
   assign rsp_chan.is_peak       = rsp_peak_ff;
   assign rsp_chan.end_of_matrix = rsp_end_ff;
   assign rsp_chan.total_peaks   = rsp_total_ff;

   // ---------------------------------------------------------------- assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= OCC_BITS'(mlpf_pkg::FIFO_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff < OCC_BITS'(mlpf_pkg::FIFO_DEPTH)))
      else $error("bundle pushed into a full queue");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff >= mlpf_pkg::count_type'(1)) && (col_ff <= col_cnt_ff)
      && (row_ff >= mlpf_pkg::count_type'(1)) && (row_ff <= row_cnt_ff))
      else $error("raster position outside the matrix");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_col && last_row) |=>
      ((row_ff == mlpf_pkg::count_type'(1)) && (col_ff == mlpf_pkg::count_type'(1))))
      else $error("position did not return to the first cell");

   a_tally_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && closing) |=> (tally_ff == '0))
      else $error("peak tally not cleared after the closing item");

endmodule

`default_nettype wire
